/* rtl/pngd_pkg.sv */
// Shared types, constants and the CRC-32 byte update for the PNG chunk deframer.
package pngd_pkg;

  // Reflected CRC-32 polynomial and initial value
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // The eight PNG file signature bytes, in order of arrival
  localparam logic [7:0] PNG_SIG [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                         8'd13, 8'd10, 8'd26, 8'd10};

  // Last byte position of each field
  localparam logic [2:0] SIG_LAST   = 3'd7;
  localparam logic [2:0] FIELD_LAST = 3'd3;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_OK     = 3'd1,
    KIND_SIGERR = 3'd2,
    KIND_CRCERR = 3'd3,
    KIND_TRUNC  = 3'd4
  } kind_e;

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_IDLE = 6'b100000
  } phase_e;

  // Everything one input byte produces: an optional main result and an
  // optional truncation result that follows it
  typedef struct packed {
    logic        has_main;
    kind_e       main_kind;
    logic [7:0]  data_byte;
    logic [31:0] type_code;
    logic [31:0] length;
    logic        has_trunc;
  } res_rec_t;

  // Fold one byte into a reflected CRC-32 register
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/pngd_parser.sv */
// Framing state machine and CRC register: turns one file byte into a result record.
module pngd_parser
  import pngd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] file_byte_i,
  input  logic       new_file_i,
  input  logic       end_of_stream_i,
  output logic       push_o,
  output res_rec_t   rec_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  fidx_q, fidx_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic [31:0] type_q, type_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rcrc_q, rcrc_d;

  // Work out the next state and the results of the byte on offer
  always_comb begin
    phase_e      ph;
    logic [31:0] left_dec;
    logic        err;
    logic        active;

    // A new file restarts from the reset state
    ph     = new_file_i ? PH_SIG : phase_q;
    fidx_d = new_file_i ? 3'd0 : fidx_q;
    len_d  = new_file_i ? 32'd0 : len_q;
    left_d = new_file_i ? 32'd0 : left_q;
    type_d = new_file_i ? 32'd0 : type_q;
    crc_d  = new_file_i ? CRC_INIT : crc_q;
    rcrc_d = new_file_i ? 32'd0 : rcrc_q;
    phase_d  = ph;
    left_dec = left_d - 32'd1;
    err      = 1'b0;
    active   = 1'b1;

    rec_o           = '0;
    rec_o.main_kind = KIND_DATA;

    unique case (ph)
      PH_SIG: begin
        if (file_byte_i != PNG_SIG[fidx_d]) begin
          rec_o.has_main  = 1'b1;
          rec_o.main_kind = KIND_SIGERR;
          err             = 1'b1;
          phase_d         = PH_IDLE;
        end else if (fidx_d == SIG_LAST) begin
          phase_d = PH_LEN;
          fidx_d  = 3'd0;
        end else begin
          fidx_d = fidx_d + 3'd1;
        end
      end
      PH_LEN: begin
        if (fidx_d == 3'd0) begin
          len_d  = {24'd0, file_byte_i};
          type_d = 32'd0;
        end else begin
          len_d = {len_d[23:0], file_byte_i};
        end
        if (fidx_d == FIELD_LAST) begin
          phase_d = PH_TYPE;
          fidx_d  = 3'd0;
        end else begin
          fidx_d = fidx_d + 3'd1;
        end
      end
      PH_TYPE: begin
        type_d = {type_d[23:0], file_byte_i};
        crc_d  = crc_byte((fidx_d == 3'd0) ? CRC_INIT : crc_d, file_byte_i);
        if (fidx_d == FIELD_LAST) begin
          fidx_d  = 3'd0;
          left_d  = len_d;
          phase_d = (len_d == 32'd0) ? PH_CRC : PH_DATA;
        end else begin
          fidx_d = fidx_d + 3'd1;
        end
      end
      PH_DATA: begin
        crc_d           = crc_byte(crc_d, file_byte_i);
        rec_o.has_main  = 1'b1;
        rec_o.main_kind = KIND_DATA;
        rec_o.data_byte = file_byte_i;
        left_d          = left_dec;
        if (left_dec == 32'd0) begin
          phase_d = PH_CRC;
          fidx_d  = 3'd0;
        end
      end
      PH_CRC: begin
        rcrc_d = {rcrc_d[23:0], file_byte_i};
        if (fidx_d == FIELD_LAST) begin
          fidx_d         = 3'd0;
          rec_o.has_main = 1'b1;
          if (~crc_d == rcrc_d) begin
            rec_o.main_kind = KIND_OK;
            phase_d         = PH_LEN;
          end else begin
            rec_o.main_kind = KIND_CRCERR;
            err             = 1'b1;
            phase_d         = PH_IDLE;
          end
        end else begin
          fidx_d = fidx_d + 3'd1;
        end
      end
      default: begin
        // Idle: drop the byte, keep everything
        active = 1'b0;
      end
    endcase

    // End of stream away from a chunk boundary means the file was cut short
    if (active && end_of_stream_i && !err) begin
      rec_o.has_trunc = !(phase_d == PH_LEN && fidx_d == 3'd0);
      phase_d         = PH_IDLE;
    end

    rec_o.type_code = type_d;
    rec_o.length    = len_d;
  end

  assign push_o = fire_i && (rec_o.has_main || rec_o.has_trunc);

  // Hold the framing state between transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG;
      fidx_q  <= 3'd0;
      len_q   <= 32'd0;
      left_q  <= 32'd0;
      type_q  <= 32'd0;
      crc_q   <= CRC_INIT;
      rcrc_q  <= 32'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      fidx_q  <= fidx_d;
      len_q   <= len_d;
      left_q  <= left_d;
      type_q  <= type_d;
      crc_q   <= crc_d;
      rcrc_q  <= rcrc_d;
    end
  end

endmodule

/* rtl/pngd_out_buf.sv */
// Two-entry result queue that unfolds each record into one or two output transactions.
module pngd_out_buf
  import pngd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  res_rec_t    rec_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] type_code_o,
  output logic [31:0] payload_length_o,
  output logic        last_in_run_o
);

  res_rec_t   rec_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       sub_q;
  logic       show_main;
  logic       out_fire;
  logic       pop;
  res_rec_t   head;

  assign head        = rec_q[rd_ptr_q];
  assign room_o      = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);

  // Main result first, then the truncation result if there is one
  assign show_main        = head.has_main && !sub_q;
  assign kind_o           = show_main ? head.main_kind : KIND_TRUNC;
  assign payload_byte_o   = (show_main && head.main_kind == KIND_DATA) ? head.data_byte : 8'd0;
  assign type_code_o      = head.type_code;
  assign payload_length_o = head.length;
  assign last_in_run_o    = show_main ? !head.has_trunc : 1'b1;

  assign out_fire = out_valid_o && out_ready_i;
  assign pop      = out_fire && last_in_run_o;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  // Store the incoming record
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rec_q[wr_ptr_q] <= rec_i;
    end
  end

  // Advance pointers, fill level and the sub-result marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
      sub_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        sub_q    <= 1'b0;
      end else if (out_fire) begin
        sub_q <= 1'b1;
      end
    end
  end

endmodule

/* rtl/png_chunk_deframer_crc_check.sv */
// PNG chunk deframer with CRC-32 check: top level.
// Takes a PNG file one byte per transaction, checks the 8-byte signature, then
// splits chunks into length, type, data and CRC, passes every data byte out and
// reports each chunk as good or as a CRC mismatch. A byte is taken in every
// cycle while the queue has room; its results are registered in a two-entry
// result queue and leave it one result per cycle while out_ready_i is high.
// The CRC-32 byte update and the framing counters are combinational logic
// between the state registers and that queue. A byte that yields both a data
// result and a truncation result gives two output transactions, so a long run
// of such outputs slows intake to match. After a signature error, CRC mismatch
// or end of stream, bytes are dropped until new_file_i is raised with a byte.
module png_chunk_deframer_crc_check
  import pngd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  file_byte_i,
  input  logic        new_file_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] type_code_o,
  output logic [31:0] payload_length_o,
  output logic        last_in_run_o
);

  logic     room;
  logic     fire;
  logic     push;
  res_rec_t rec;

  assign in_ready_o = room;
  assign fire       = in_valid_i && room;

  pngd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .file_byte_i     (file_byte_i),
    .new_file_i      (new_file_i),
    .end_of_stream_i (end_of_stream_i),
    .push_o          (push),
    .rec_o           (rec)
  );

  pngd_out_buf u_out_buf (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .rec_i            (rec),
    .room_o           (room),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .payload_byte_o   (payload_byte_o),
    .type_code_o      (type_code_o),
    .payload_length_o (payload_length_o),
    .last_in_run_o    (last_in_run_o)
  );

endmodule

/* rtl/pngd_checker.sv */
// Port-level assertions for the PNG chunk deframer, bound to the top level.
module pngd_checker
  import pngd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [31:0] type_code_o,
  input logic [31:0] payload_length_o,
  input logic        last_in_run_o
);

  // A stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(kind_o) && $stable(payload_byte_o) && $stable(last_in_run_o))
    else $error("stalled result changed");

  // Only data results carry a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> payload_byte_o == 8'd0)
    else $error("non-data result with a byte");

  // Status results close the run of their byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> last_in_run_o)
    else $error("status result not last in run");

  // A signature error comes before any chunk field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SIGERR |->
      type_code_o == 32'd0 && payload_length_o == 32'd0)
    else $error("signature error with chunk fields");

endmodule

bind png_chunk_deframer_crc_check pngd_checker u_pngd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .kind_o           (kind_o),
  .payload_byte_o   (payload_byte_o),
  .type_code_o      (type_code_o),
  .payload_length_o (payload_length_o),
  .last_in_run_o    (last_in_run_o)
);

/* sim/pngd_chunk_monitor.sv */
// Monitor for the PNG chunk deframer: predicts every result from the byte stream and checks it.
module pngd_chunk_monitor
  import pngd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  file_byte_i,
  input  logic        new_file_i,
  input  logic        end_of_stream_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  payload_byte_i,
  input  logic [31:0] type_code_i,
  input  logic [31:0] payload_length_i,
  input  logic        last_in_run_i,
  output int          fail_count_o,
  output int          outstanding_o,
  output int          checked_o,
  output int          chunks_ok_o
);

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [31:0] type_code;
    logic [31:0] length;
    logic        last;
  } deframe_result_t;

  // Parser state as the block should hold it
  phase_e      phase;
  logic [2:0]  field_pos;
  logic [31:0] chunk_len;
  logic [31:0] data_left;
  logic [31:0] chunk_type;
  logic [31:0] crc_acc;
  logic [31:0] crc_rx;

  deframe_result_t expected_q[$];
  int fails;
  int checked;
  int chunks_ok;

  assign fail_count_o = fails;
  assign checked_o    = checked;
  assign chunks_ok_o  = chunks_ok;

  initial begin
    fails     = 0;
    checked   = 0;
    chunks_ok = 0;
  end

  // Fold one byte into the reflected CRC-32, one bit at a time, LSB first
  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] d);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic deframe_result_t result_of(input kind_e k, input logic [7:0] d);
    deframe_result_t r;
    r.kind      = k;
    r.data      = d;
    r.type_code = chunk_type;
    r.length    = chunk_len;
    r.last      = 1'b0;
    return r;
  endfunction

  task automatic clear_parser();
    phase      = PH_SIG;
    field_pos  = '0;
    chunk_len  = '0;
    data_left  = '0;
    chunk_type = '0;
    crc_acc    = CRC_INIT;
    crc_rx     = '0;
  endtask

  // Advance the parser by one byte and queue the results it should give
  task automatic deframe_byte(input logic [7:0] b, input logic nf, input logic eos);
    deframe_result_t res [2];
    int   n;
    logic err;
    n   = 0;
    err = 1'b0;
    if (nf) clear_parser();
    // Idle: drop the byte, ignore its end marker
    if (phase == PH_IDLE) return;
    case (phase)
      PH_SIG: begin
        if (b != PNG_SIG[field_pos]) begin
          res[n] = result_of(KIND_SIGERR, 8'd0);
          n++;
          err   = 1'b1;
          phase = PH_IDLE;
        end else if (field_pos == SIG_LAST) begin
          phase     = PH_LEN;
          field_pos = '0;
        end else begin
          field_pos++;
        end
      end
      PH_LEN: begin
        if (field_pos == 0) begin
          chunk_len  = {24'd0, b};
          chunk_type = '0;
        end else begin
          chunk_len = {chunk_len[23:0], b};
        end
        if (field_pos == FIELD_LAST) begin
          phase     = PH_TYPE;
          field_pos = '0;
        end else begin
          field_pos++;
        end
      end
      PH_TYPE: begin
        if (field_pos == 0) crc_acc = CRC_INIT;
        chunk_type = {chunk_type[23:0], b};
        crc_acc    = crc32_update(crc_acc, b);
        if (field_pos == FIELD_LAST) begin
          field_pos = '0;
          data_left = chunk_len;
          phase     = (chunk_len == 0) ? PH_CRC : PH_DATA;
        end else begin
          field_pos++;
        end
      end
      PH_DATA: begin
        crc_acc = crc32_update(crc_acc, b);
        res[n]  = result_of(KIND_DATA, b);
        n++;
        data_left = data_left - 1;
        if (data_left == 0) begin
          phase     = PH_CRC;
          field_pos = '0;
        end
      end
      PH_CRC: begin
        crc_rx = {crc_rx[23:0], b};
        if (field_pos == FIELD_LAST) begin
          field_pos = '0;
          if (~crc_acc == crc_rx) begin
            res[n] = result_of(KIND_OK, 8'd0);
            n++;
            phase = PH_LEN;
          end else begin
            res[n] = result_of(KIND_CRCERR, 8'd0);
            n++;
            err   = 1'b1;
            phase = PH_IDLE;
          end
        end else begin
          field_pos++;
        end
      end
      default: ;
    endcase
    // End of stream: clean only at the start of a length field
    if (eos && !err) begin
      if (!(phase == PH_LEN && field_pos == 0)) begin
        res[n] = result_of(KIND_TRUNC, 8'd0);
        n++;
      end
      phase = PH_IDLE;
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_q.push_back(res[i]);
  endtask

  // Compare one result transaction against the oldest expectation
  task automatic check_result();
    deframe_result_t want;
    if (expected_q.size() == 0) begin
      $error("result with none expected: kind %0d", kind_i);
      fails++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (want.kind == KIND_OK) chunks_ok++;
    if (kind_i !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, kind_i);
      fails++;
    end
    if (payload_byte_i !== want.data) begin
      $error("payload_byte: expected %0h, got %0h", want.data, payload_byte_i);
      fails++;
    end
    if (type_code_i !== want.type_code) begin
      $error("type_code: expected %0h, got %0h", want.type_code, type_code_i);
      fails++;
    end
    if (payload_length_i !== want.length) begin
      $error("payload_length: expected %0h, got %0h", want.length, payload_length_i);
      fails++;
    end
    if (last_in_run_i !== want.last) begin
      $error("last_in_run: expected %0b, got %0b", want.last, last_in_run_i);
      fails++;
    end
  endtask

  // Predict on each input transaction, check on each result transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      expected_q.delete();
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) deframe_byte(file_byte_i, new_file_i, end_of_stream_i);
      if (out_valid_i && out_ready_i) check_result();
      outstanding_o <= expected_q.size();
    end
  end

endmodule

/* sim/png_chunk_deframer_crc_check_tb.sv */
// Testbench top for the PNG chunk deframer: builds byte streams, drives both channels, gives the verdict.
module png_chunk_deframer_crc_check_tb;
  import pngd_pkg::*;

  localparam int ITEMS = 1300;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  file_byte_i     = 8'd0;
  logic        new_file_i      = 1'b0;
  logic        end_of_stream_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic [31:0] type_code_o;
  logic [31:0] payload_length_o;
  logic        last_in_run_o;

  int fail_count;
  int outstanding;
  int checked;
  int chunks_ok;

  logic [7:0] file_q[$];
  int  bytes_sent = 0;
  int  files      = 0;
  int  stall_left = 0;
  bit  quiet      = 1'b0;
  bit  gappy      = 1'b0;
  bit  mid_drain  = 1'b0;

  png_chunk_deframer_crc_check dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .file_byte_i,
    .new_file_i,
    .end_of_stream_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .payload_byte_o,
    .type_code_o,
    .payload_length_o,
    .last_in_run_o
  );

  pngd_chunk_monitor mon (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i       (in_ready_o),
    .file_byte_i,
    .new_file_i,
    .end_of_stream_i,
    .out_valid_i      (out_valid_o),
    .out_ready_i,
    .kind_i           (kind_o),
    .payload_byte_i   (payload_byte_o),
    .type_code_i      (type_code_o),
    .payload_length_i (payload_length_o),
    .last_in_run_i    (last_in_run_o),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding),
    .checked_o        (checked),
    .chunks_ok_o      (chunks_ok)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result channel in random bursts, none in the quiet tail
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 9);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Hold one byte on the input channel until it is taken
  task automatic put_byte(input logic [7:0] b, input logic nf, input logic eos);
    if (!quiet && gappy && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    file_byte_i     <= b;
    new_file_i      <= nf;
    end_of_stream_i <= eos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Append length, type, data and (if sealed) CRC; fill < 0 means random bytes
  task automatic add_chunk(input logic [31:0] len, input int data_cnt, input int fill,
                           input bit bad_crc, input bit sealed);
    logic [31:0] crc;
    logic [7:0]  b;
    for (int i = 3; i >= 0; i--) file_q.push_back(len[8*i +: 8]);
    crc = CRC_INIT;
    for (int i = 0; i < 4 + data_cnt; i++) begin
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      file_q.push_back(b);
      crc = crc_byte(crc, b);
    end
    crc = ~crc;
    if (bad_crc) crc[$urandom_range(0, 31)] ^= 1'b1;
    if (sealed) for (int i = 3; i >= 0; i--) file_q.push_back(crc[8*i +: 8]);
  endtask

  task automatic send_file(input bit with_eos);
    for (int i = 0; i < file_q.size(); i++)
      put_byte(file_q[i], i == 0, with_eos && i == file_q.size() - 1);
    bytes_sent += file_q.size();
    files++;
  endtask

  // Pause the sender until every expected result has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // One random file: mostly well formed, the rest cut short, corrupted or noise
  task automatic run_random_file();
    int          mode;
    int          chunks;
    int          cut;
    int          bad_at;
    logic [31:0] len;
    bit          with_eos;
    file_q.delete();
    with_eos = 1'b1;
    gappy    = ($urandom_range(0, 2) != 0);
    mode     = $urandom_range(0, 99);
    chunks   = $urandom_range(0, 4);
    if (mode >= 62 && mode < 72 && chunks == 0) chunks = 1;
    bad_at = (mode >= 62 && mode < 72) ? $urandom_range(0, chunks - 1) : -1;
    for (int i = 0; i < 8; i++) file_q.push_back(PNG_SIG[i]);
    for (int c = 0; c < chunks; c++) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
      add_chunk(len, len, -1, c == bad_at, 1'b1);
    end
    // huge length: only a few data bytes follow before the end marker
    if (mode >= 88 && mode < 94) add_chunk($urandom | 32'h8000_0000, $urandom_range(0, 6), -1,
                                           1'b0, 1'b0);
    if (mode >= 50 && mode < 62) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else if (mode >= 72 && mode < 80) begin
      cut = $urandom_range(0, 7);
      file_q[cut] = file_q[cut] ^ (8'd1 << $urandom_range(0, 7));
    end else if (mode >= 80 && mode < 88) begin
      with_eos = 1'b0;
    end else if (mode >= 94) begin
      file_q.delete();
      repeat ($urandom_range(1, 20)) file_q.push_back(8'($urandom_range(0, 255)));
    end
    send_file(with_eos);
    // stray bytes after the end are dropped by the block
    if (with_eos) repeat ($urandom_range(0, 2))
      put_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad first byte, ignored byte, minimal file, end marker inside the signature
    gappy = 1'b1;
    put_byte(8'h00, 1'b1, 1'b0);
    put_byte(8'hFF, 1'b0, 1'b0);
    file_q.delete();
    for (int i = 0; i < 8; i++) file_q.push_back(PNG_SIG[i]);
    add_chunk(32'd1, 1, 8'hFF, 1'b0, 1'b1);
    send_file(1'b1);
    put_byte(PNG_SIG[0], 1'b1, 1'b1);
    wait_drained();

    // Random files until the byte budget is spent
    while (bytes_sent < ITEMS) begin
      if (bytes_sent > ITEMS * 85 / 100) quiet <= 1'b1;
      run_random_file();
      if (!mid_drain && bytes_sent > ITEMS / 2) begin
        wait_drained();
        mid_drain = 1'b1;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("covered %0d files, %0d file bytes: %0d results checked, %0d chunks with good CRC",
             files, bytes_sent, checked, chunks_ok);
    $display("including bad signatures, CRC mismatches, cut-off streams and huge lengths");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
rtl/pngd_pkg.sv
rtl/pngd_parser.sv
rtl/pngd_out_buf.sv
rtl/png_chunk_deframer_crc_check.sv
rtl/pngd_checker.sv
sim/pngd_chunk_monitor.sv
sim/png_chunk_deframer_crc_check_tb.sv
